### rtl/cdp_pkg.sv
// Package for the cookie date parser: types, codes and helpers.
// No dependencies; used by every module under rtl.
package cdp_pkg;

    // time scan phases
    typedef enum logic [2:0] {
        TS_HOUR   = 3'd0,
        TS_MINUTE = 3'd1,
        TS_SECOND = 3'd2,
        TS_MATCH  = 3'd3,
        TS_FAIL   = 3'd4
    } time_phase_t;

    // converter sequencer states
    typedef enum logic [2:0] {
        CV_IDLE,
        CV_DIV,
        CV_CHECK,
        CV_DOE,
        CV_DAYS,
        CV_MUL,
        CV_ADD,
        CV_DONE
    } conv_state_t;

    // shared unit operation codes, in issue order
    typedef enum logic [1:0] {
        OP_MUL_DAYS,
        OP_MUL_HOUR,
        OP_MUL_MIN,
        OP_MUL_SEC
    } mul_op_t;

    // finished date fields handed to the converter
    typedef struct packed {
        logic        all_found;
        logic [13:0] year;
        logic [3:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } date_fields_t;

    function automatic logic is_delim(input logic [7:0] c);
        return (c == 8'h09) || (c >= 8'h20 && c <= 8'h2f) ||
               (c >= 8'h3b && c <= 8'h40) || (c >= 8'h5b && c <= 8'h60) ||
               (c >= 8'h7b && c <= 8'h7e);
    endfunction

    // month number from three lowercase letters packed low byte first, 0 if none
    function automatic logic [3:0] month_code(input logic [23:0] h);
        logic [3:0] m;
        m = 4'd0;
        case (h)
            {8'h6e, 8'h61, 8'h6a}: m = 4'd1;
            {8'h62, 8'h65, 8'h66}: m = 4'd2;
            {8'h72, 8'h61, 8'h6d}: m = 4'd3;
            {8'h72, 8'h70, 8'h61}: m = 4'd4;
            {8'h79, 8'h61, 8'h6d}: m = 4'd5;
            {8'h6e, 8'h75, 8'h6a}: m = 4'd6;
            {8'h6c, 8'h75, 8'h6a}: m = 4'd7;
            {8'h67, 8'h75, 8'h61}: m = 4'd8;
            {8'h70, 8'h65, 8'h73}: m = 4'd9;
            {8'h74, 8'h63, 8'h6f}: m = 4'd10;
            {8'h76, 8'h6f, 8'h6e}: m = 4'd11;
            {8'h63, 8'h65, 8'h64}: m = 4'd12;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

endpackage

### rtl/cdp_tokenizer.sv
// Byte tokenizer: splits the date string into tokens and keeps found fields.
// Depends on cdp_pkg.
module cdp_tokenizer
    import cdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_take,
    input  logic [7:0]   text_byte,
    input  logic         last_byte,
    output logic         fields_ready,
    output date_fields_t fields
);

    logic [2:0]  tok_len_reg, tok_len_next;
    logic [2:0]  lead_cnt_reg, lead_cnt_next;
    logic [13:0] lead_val_reg, lead_val_next;
    logic [23:0] head_reg, head_next;
    time_phase_t phase_reg, phase_next;
    logic [1:0]  part_dig_reg, part_dig_next;
    logic [6:0]  sh_reg, sh_next, sm_reg, sm_next, ss_reg, ss_next;
    logic [3:0]  found_reg, found_next;
    logic [6:0]  day_reg, day_next;
    logic [3:0]  mon_reg, mon_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  hr_reg, hr_next, mi_reg, mi_next, se_reg, se_next;
    logic        ready_reg, ready_next;

    logic        digit, delim, time_ok;
    logic [3:0]  dval;
    logic [7:0]  lc;
    logic [3:0]  mcode;
    logic [3:0]  fnd_c;
    logic [6:0]  day_c, hr_c, mi_c, se_c;
    logic [3:0]  mon_c;
    logic [13:0] year_c;

    assign digit = text_byte >= 8'h30 && text_byte <= 8'h39;
    assign dval  = text_byte[3:0];
    assign delim = is_delim(text_byte);
    assign lc    = (text_byte >= 8'h41 && text_byte <= 8'h5a) ? text_byte + 8'h20
                                                               : text_byte;
    assign mcode = month_code(head_reg);
    assign time_ok = phase_reg == TS_MATCH ||
                     (phase_reg == TS_SECOND && part_dig_reg != 2'd0);

    // token close: classify the open token into the kept fields
    always_comb
    begin
        fnd_c = found_reg; day_c = day_reg; mon_c = mon_reg; year_c = year_reg;
        hr_c = hr_reg; mi_c = mi_reg; se_c = se_reg;
        if (tok_len_reg != 3'd0)
        begin
            if (!found_reg[0] && time_ok)
            begin
                fnd_c[0] = 1'b1; hr_c = sh_reg; mi_c = sm_reg; se_c = ss_reg;
            end
            else if (!found_reg[1] && lead_cnt_reg >= 3'd1 && lead_cnt_reg <= 3'd2)
            begin
                fnd_c[1] = 1'b1; day_c = lead_val_reg[6:0];
            end
            else if (!found_reg[2] && tok_len_reg >= 3'd3 && mcode != 4'd0)
            begin
                fnd_c[2] = 1'b1; mon_c = mcode;
            end
            else if (!found_reg[3] && lead_cnt_reg >= 3'd1 && lead_cnt_reg <= 3'd4)
            begin
                fnd_c[3] = 1'b1; year_c = lead_val_reg;
            end
        end
    end

    // per-byte update
    always_comb
    begin
        tok_len_next = tok_len_reg; lead_cnt_next = lead_cnt_reg;
        lead_val_next = lead_val_reg; head_next = head_reg; phase_next = phase_reg;
        part_dig_next = part_dig_reg; sh_next = sh_reg; sm_next = sm_reg;
        ss_next = ss_reg; found_next = found_reg; day_next = day_reg;
        mon_next = mon_reg; year_next = year_reg; hr_next = hr_reg;
        mi_next = mi_reg; se_next = se_reg; ready_next = 1'b0;
        if (byte_take)
        begin
            if (delim)
            begin
                found_next = fnd_c; day_next = day_c; mon_next = mon_c;
                year_next = year_c; hr_next = hr_c; mi_next = mi_c; se_next = se_c;
            end
            if (delim)
            begin
                tok_len_next = '0; lead_cnt_next = '0; lead_val_next = '0;
                head_next = '0; phase_next = TS_HOUR; part_dig_next = '0;
                sh_next = '0; sm_next = '0; ss_next = '0;
            end
            else
            begin
                if (tok_len_reg == 3'd0) head_next[7:0] = lc;
                if (tok_len_reg == 3'd1) head_next[15:8] = lc;
                if (tok_len_reg == 3'd2) head_next[23:16] = lc;
                if (digit && lead_cnt_reg == tok_len_reg)
                begin
                    lead_cnt_next = (lead_cnt_reg < 3'd5) ? lead_cnt_reg + 3'd1 : 3'd5;
                    if (lead_cnt_reg < 3'd4)
                        lead_val_next = 14'(lead_val_reg * 14'd10 + 14'(dval));
                end
                if (phase_reg == TS_HOUR || phase_reg == TS_MINUTE ||
                    phase_reg == TS_SECOND)
                begin
                    if (digit)
                    begin
                        if (part_dig_reg >= 2'd2)
                            phase_next = TS_FAIL;
                        else
                        begin
                            part_dig_next = part_dig_reg + 2'd1;
                            if (phase_reg == TS_HOUR)
                                sh_next = 7'(sh_reg * 7'd10 + 7'(dval));
                            else if (phase_reg == TS_MINUTE)
                                sm_next = 7'(sm_reg * 7'd10 + 7'(dval));
                            else
                                ss_next = 7'(ss_reg * 7'd10 + 7'(dval));
                        end
                    end
                    else if (phase_reg == TS_SECOND)
                        phase_next = (part_dig_reg != 2'd0) ? TS_MATCH : TS_FAIL;
                    else if (text_byte == 8'h3a && part_dig_reg != 2'd0)
                    begin
                        phase_next = (phase_reg == TS_HOUR) ? TS_MINUTE : TS_SECOND;
                        part_dig_next = '0;
                    end
                    else
                        phase_next = TS_FAIL;
                end
                tok_len_next = (tok_len_reg < 3'd7) ? tok_len_reg + 3'd1 : 3'd7;
            end
            if (last_byte)
            begin
                // the last byte's token is closed in the following cycle
                ready_next = 1'b1;
            end
        end
        else if (ready_reg)
        begin
            // final close has been handed over: reset all parse state
            tok_len_next = '0; lead_cnt_next = '0; lead_val_next = '0;
            head_next = '0; phase_next = TS_HOUR; part_dig_next = '0;
            sh_next = '0; sm_next = '0; ss_next = '0; found_next = '0;
            day_next = '0; mon_next = '0; year_next = '0;
            hr_next = '0; mi_next = '0; se_next = '0;
        end
    end

    // fields after the final close, valid in the cycle after the last byte
    assign fields_ready = ready_reg;
    assign fields.all_found = &fnd_c;
    assign fields.year   = year_c;
    assign fields.month  = mon_c;
    assign fields.day    = day_c;
    assign fields.hour   = hr_c;
    assign fields.minute = mi_c;
    assign fields.second = se_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg <= '0; lead_cnt_reg <= '0; lead_val_reg <= '0;
            head_reg <= '0; phase_reg <= TS_HOUR; part_dig_reg <= '0;
            sh_reg <= '0; sm_reg <= '0; ss_reg <= '0; found_reg <= '0;
            day_reg <= '0; mon_reg <= '0; year_reg <= '0;
            hr_reg <= '0; mi_reg <= '0; se_reg <= '0; ready_reg <= 1'b0;
        end
        else
        begin
            tok_len_reg <= tok_len_next; lead_cnt_reg <= lead_cnt_next;
            lead_val_reg <= lead_val_next; head_reg <= head_next;
            phase_reg <= phase_next; part_dig_reg <= part_dig_next;
            sh_reg <= sh_next; sm_reg <= sm_next; ss_reg <= ss_next;
            found_reg <= found_next; day_reg <= day_next; mon_reg <= mon_next;
            year_reg <= year_next; hr_reg <= hr_next; mi_reg <= mi_next;
            se_reg <= se_next; ready_reg <= ready_next;
        end
    end

endmodule

### rtl/cdp_converter.sv
// Date check and epoch conversion around one shared multiply-add unit.
// Depends on cdp_pkg.
module cdp_converter
    import cdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  date_fields_t      fields,
    output logic              busy,
    output logic              done,
    output logic              ok,
    output logic signed [38:0] secs
);

    conv_state_t state_reg, state_next;
    date_fields_t f_reg;
    logic [13:0] year_reg;
    logic [13:0] yy_reg;
    logic        bad_reg, bad_next;
    logic signed [38:0] acc_reg, acc_next;
    mul_op_t     step_reg, step_next;
    logic [6:0]  q100_reg;
    logic [4:0]  era_reg;
    logic [8:0]  yoe_reg;
    logic [8:0]  doy_reg;
    logic [17:0] doe_reg;
    logic signed [22:0] days_reg;

    logic [13:0] y_adj, yy_c;
    logic [27:0] q100_prod;
    logic [26:0] era_prod;
    logic [13:0] r100;
    logic        leap, chk_bad;
    logic [3:0]  mp;
    logic [8:0]  mstart;
    logic [8:0]  doy_c;
    logic [8:0]  yoe_c;
    logic [13:0] c100_prod;
    logic [17:0] doe_c;
    logic signed [22:0] days_c;
    logic signed [22:0] mul_a;
    logic [16:0] mul_b;
    logic signed [38:0] product;

    // two-digit year mapping; March-based year
    always_comb
    begin
        if (fields.year <= 14'd69) y_adj = fields.year + 14'd2000;
        else if (fields.year <= 14'd99) y_adj = fields.year + 14'd1900;
        else y_adj = fields.year;
        yy_c = y_adj - ((fields.month <= 4'd2) ? 14'd1 : 14'd0);
    end

    // reciprocal division: year / 100 and yy / 400, exact below 12800
    assign q100_prod = 28'(year_reg) * 28'd10486;
    assign era_prod  = 27'(yy_reg) * 27'd5243;

    // range and month-length checks on the latched fields
    assign r100 = year_reg - 14'(14'(q100_reg) * 14'd100);
    assign leap = year_reg[1:0] == 2'b00 && (r100 != 14'd0 || q100_reg[1:0] == 2'b00);
    always_comb
    begin
        chk_bad = !f_reg.all_found || f_reg.day < 7'd1 || f_reg.day > 7'd31 ||
                  year_reg < 14'd1601 || f_reg.hour > 7'd23 ||
                  f_reg.minute > 7'd59 || f_reg.second > 7'd59 ||
                  f_reg.month < 4'd1 || f_reg.month > 4'd12;
        if ((f_reg.month == 4'd4 || f_reg.month == 4'd6 || f_reg.month == 4'd9 ||
             f_reg.month == 4'd11) && f_reg.day > 7'd30)
            chk_bad = 1'b1;
        if (f_reg.month == 4'd2 && f_reg.day > (leap ? 7'd29 : 7'd28))
            chk_bad = 1'b1;
    end

    // day of March-based year: month start table plus day
    always_comb
    begin
        mp = (f_reg.month > 4'd2) ? f_reg.month - 4'd3 : f_reg.month + 4'd9;
        unique case (mp)
            4'd0:    mstart = 9'd0;
            4'd1:    mstart = 9'd31;
            4'd2:    mstart = 9'd61;
            4'd3:    mstart = 9'd92;
            4'd4:    mstart = 9'd122;
            4'd5:    mstart = 9'd153;
            4'd6:    mstart = 9'd184;
            4'd7:    mstart = 9'd214;
            4'd8:    mstart = 9'd245;
            4'd9:    mstart = 9'd275;
            4'd10:   mstart = 9'd306;
            4'd11:   mstart = 9'd337;
            default: mstart = 9'd0;
        endcase
        doy_c = 9'(mstart + 9'(f_reg.day) - 9'd1);
        yoe_c = 9'(yy_reg - 14'(14'(era_reg) * 14'd400));
    end

    // day of era, then days since 1970
    assign c100_prod = 14'(yoe_reg) * 14'd41;
    assign doe_c  = 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) -
                    18'(c100_prod[13:12]) + 18'(doy_reg);
    assign days_c = $signed(23'(era_reg) * 23'd146097 + 23'(doe_reg) - 23'd719468);

    // shared multiplier: one product per step
    always_comb
    begin
        unique case (step_reg)
            OP_MUL_DAYS: begin mul_a = days_reg; mul_b = 17'd86400; end
            OP_MUL_HOUR: begin mul_a = 23'(f_reg.hour); mul_b = 17'd3600; end
            OP_MUL_MIN:  begin mul_a = 23'(f_reg.minute); mul_b = 17'd60; end
            default:     begin mul_a = 23'(f_reg.second); mul_b = 17'd1; end
        endcase
        product = 39'(mul_a * $signed({1'b0, mul_b}));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:  if (start) state_next = CV_DIV;
            CV_DIV:   state_next = CV_CHECK;
            CV_CHECK: state_next = chk_bad ? CV_DONE : CV_DOE;
            CV_DOE:   state_next = CV_DAYS;
            CV_DAYS:  state_next = CV_MUL;
            CV_MUL:   if (step_reg == OP_MUL_SEC) state_next = CV_ADD;
            CV_ADD:   state_next = CV_DONE;
            CV_DONE:  state_next = CV_IDLE;
            default:  state_next = CV_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        bad_next  = bad_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        unique case (state_reg)
            CV_IDLE:  begin bad_next = 1'b0; acc_next = '0; step_next = OP_MUL_DAYS; end
            CV_CHECK: bad_next = chk_bad;
            CV_MUL:
            begin
                acc_next  = acc_reg + product;
                step_next = mul_op_t'(step_reg + 2'd1);
            end
            CV_ADD:   if (acc_reg == -39'sd1) bad_next = 1'b1;
            default:  ;
        endcase
    end

    assign busy = state_reg != CV_IDLE;
    assign done = state_reg == CV_DONE;
    assign ok   = !bad_reg;
    assign secs = bad_reg ? 39'sd0 : acc_reg;

    // stage registers of the conversion
    always_ff @(posedge clk)
    begin
        if (start && state_reg == CV_IDLE)
        begin
            f_reg    <= fields;
            year_reg <= y_adj;
            yy_reg   <= yy_c;
        end
        if (state_reg == CV_DIV)
        begin
            q100_reg <= q100_prod[26:20];
            era_reg  <= era_prod[25:21];
        end
        if (state_reg == CV_CHECK)
        begin
            yoe_reg <= yoe_c;
            doy_reg <= doy_c;
        end
        if (state_reg == CV_DOE)
            doe_reg <= doe_c;
        if (state_reg == CV_DAYS)
            days_reg <= days_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            bad_reg   <= 1'b0;
            acc_reg   <= '0;
            step_reg  <= OP_MUL_DAYS;
        end
        else
        begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/cookie_date_parser_unit.sv
// Top level of the cookie date parser: tokenizer, converter, output register.
// Depends on cdp_pkg, cdp_tokenizer and cdp_converter.
//
// Usage: the date string enters one byte per request on text_byte, with
// last_byte high on the final byte. Non-final bytes give no result and do
// not hold off the next byte. The final byte gives one result request
// (date_valid, epoch_seconds): out_valid rises once the last token is
// closed, a division step, a range check, two day-count steps, four passes
// of the shared multiply-add unit, a -1 check and the output load are done,
// or once the close, division step, range check and output load are done
// when the checks fail. Input stall is held high from the final byte until
// its result is in the output register, so the next string's first byte is
// not taken before that result is loaded.
// The result sits in an output register; a stalled result holds, and the
// next string's bytes are still taken while it waits, but the next final
// byte waits until the register is free.
// Reset clears all parse state and drops out_valid.
module cookie_date_parser_unit
    import cdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        text_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              date_valid,
    output logic signed [38:0] epoch_seconds
);

    logic         take;
    logic         fields_ready;
    date_fields_t fields;
    logic         conv_busy, conv_done, conv_ok;
    logic signed [38:0] conv_secs;
    logic         pend_reg, pend_next;
    logic         ov_reg, ov_next;
    logic         dv_reg;
    logic signed [38:0] es_reg;

    // hold off while a string is being finished, or a final byte while the result slot is full
    assign in_stall = pend_reg || (last_byte && ov_reg);
    assign take = in_valid && !in_stall;

    cdp_tokenizer u_tok (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_take    (take),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .fields_ready (fields_ready),
        .fields       (fields)
    );

    cdp_converter u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fields_ready),
        .fields(fields),
        .busy  (conv_busy),
        .done  (conv_done),
        .ok    (conv_ok),
        .secs  (conv_secs)
    );

    // pending flag and output register control
    always_comb
    begin
        pend_next = pend_reg;
        if (take && last_byte) pend_next = 1'b1;
        else if (conv_done) pend_next = 1'b0;
        ov_next = ov_reg;
        if (out_valid && !out_stall) ov_next = 1'b0;
        if (conv_done) ov_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (conv_done)
        begin
            dv_reg <= conv_ok;
            es_reg <= conv_secs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next || (conv_busy && !conv_done);
            ov_reg   <= ov_next;
        end
    end

    assign out_valid     = ov_reg;
    assign date_valid    = dv_reg;
    assign epoch_seconds = es_reg;

endmodule

### verif/testbench.sv
// Self-checking testbench for cookie_date_parser_unit: byte-stream stimulus,
// a built-in date recognizer predictor and an in-order result scoreboard.
// Depends on cdp_pkg and the RTL under rtl.
module testbench;
    import cdp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        text_byte;
    logic              last_byte;
    logic              out_valid;
    logic              out_stall;
    logic              date_valid;
    logic signed [38:0] epoch_seconds;

    cookie_date_parser_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .text_byte(text_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .date_valid(date_valid), .epoch_seconds(epoch_seconds)
    );

    typedef struct packed {
        logic        ok;
        logic [38:0] secs;
    } date_result_t;

    // predictor state
    int unsigned tok_len, lead_cnt, lead_val, head3, tphase, tdigits;
    int unsigned hh, mm, ss, found, k_day, k_mon, k_year, k_time;

    date_result_t pending_dates[$];
    int  errors;
    int  cycles;
    bit  hold_off;
    bit  hold_used;
    int  hold_cnt;
    bit  long_quiet;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    always #10 clk = ~clk;

    function automatic bit delim_byte(input int unsigned c);
        return c == 8'h09 || (c >= 8'h20 && c <= 8'h2f) || (c >= 8'h3b && c <= 8'h40) ||
               (c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
    endfunction

    task automatic clear_token();
        tok_len = 0; lead_cnt = 0; lead_val = 0; head3 = 0;
        tphase = TS_HOUR; tdigits = 0; hh = 0; mm = 0; ss = 0;
    endtask

    task automatic clear_all();
        clear_token();
        found = 0; k_day = 0; k_mon = 0; k_year = 0; k_time = 0;
    endtask

    task automatic add_char(input int unsigned c);
        bit dig;
        int unsigned d;
        dig = c >= 8'h30 && c <= 8'h39;
        d = c - 8'h30;
        if (tok_len < 3)
            head3 |= ((c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c) << (8 * tok_len);
        if (dig && lead_cnt == tok_len) begin
            lead_cnt = lead_cnt < 5 ? lead_cnt + 1 : 5;
            if (lead_cnt <= 4)
                lead_val = lead_val * 10 + d;
        end
        if (tphase <= TS_SECOND) begin
            if (dig) begin
                if (tdigits >= 2)
                    tphase = TS_FAIL;
                else begin
                    tdigits++;
                    if (tphase == TS_HOUR) hh = hh * 10 + d;
                    else if (tphase == TS_MINUTE) mm = mm * 10 + d;
                    else ss = ss * 10 + d;
                end
            end
            else if (tphase == TS_SECOND)
                tphase = tdigits != 0 ? TS_MATCH : TS_FAIL;
            else if (c == 8'h3a && tdigits != 0) begin
                tphase++;
                tdigits = 0;
            end
            else
                tphase = TS_FAIL;
        end
        tok_len = tok_len < 7 ? tok_len + 1 : 7;
    endtask

    function automatic int unsigned month_of(input int unsigned h);
        string names;
        names = "janfebmaraprmayjunjulaugsepoctnovdec";
        for (int k = 0; k < 12; k++)
            if (h == {names[3*k+2], names[3*k+1], names[3*k]})
                return k + 1;
        return 0;
    endfunction

    task automatic close_tok();
        int unsigned m;
        bit t_ok;
        if (tok_len == 0)
            return;
        m = month_of(head3);
        t_ok = tphase == TS_MATCH || (tphase == TS_SECOND && tdigits != 0);
        if (!found[0] && t_ok) begin
            found |= 1;
            k_time = (hh & 127) | ((mm & 127) << 7) | ((ss & 127) << 14);
        end
        else if (!found[1] && lead_cnt >= 1 && lead_cnt <= 2) begin
            found |= 2; k_day = lead_val & 127;
        end
        else if (!found[2] && tok_len >= 3 && m != 0) begin
            found |= 4; k_mon = m;
        end
        else if (!found[3] && lead_cnt >= 1 && lead_cnt <= 4) begin
            found |= 8; k_year = lead_val & 16'h3fff;
        end
        clear_token();
    endtask

    function automatic date_result_t to_epoch();
        date_result_t r;
        longint y, mo, d, h, mi, s, yy, era, yoe, doy, doe, days, secs;
        bit leap;
        r = '0;
        y = k_year; mo = k_mon; d = k_day;
        h = k_time & 127; mi = (k_time >> 7) & 127; s = (k_time >> 14) & 127;
        if (y <= 69) y += 2000;
        else if (y <= 99) y += 1900;
        if (found != 15 || d < 1 || d > 31 || y < 1601 || h > 23 || mi > 59 || s > 59 ||
            mo < 1 || mo > 12)
            return r;
        if ((mo == 4 || mo == 6 || mo == 9 || mo == 11) && d > 30)
            return r;
        leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        if (mo == 2 && d > (leap ? 29 : 28))
            return r;
        yy = y - (mo <= 2 ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        secs = days * 86400 + h * 3600 + mi * 60 + s;
        if (secs == -1)
            return r;
        r.ok = 1'b1;
        r.secs = secs[38:0];
        return r;
    endfunction

    // predict one accepted request; queue a result on the final byte
    task automatic predict_byte(input logic [7:0] c, input logic lst);
        if (delim_byte(c)) close_tok();
        else add_char(c);
        if (lst) begin
            close_tok();
            pending_dates.insert(pending_dates.size(), to_epoch());
            clear_all();
        end
    endtask

    // send one request, waiting for acceptance; idles only between requests
    task automatic send_byte(input logic [7:0] c, input logic lst);
        if (!long_quiet && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_byte(c, lst);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // random date string, mostly well formed
    function automatic string rand_date();
        string s, mon, sep;
        string names[12];
        int kind;
        names = '{"Jan", "feb", "MAR", "apr", "May", "JUN", "jul", "Aug", "sep",
                  "OCT", "Nov", "dec"};
        kind = $urandom_range(99);
        sep = ($urandom_range(3) == 0) ? ", " : " ";
        mon = names[$urandom_range(11)];
        if ($urandom_range(2) == 0) mon = {mon, "ember"};
        if (kind < 70) begin
            s = $sformatf("%0d%s%s%s%0d%s%0d:%0d:%0d", $urandom_range(0, 32), sep, mon, sep,
                $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(1500, 9999),
                sep, $urandom_range(0, 25), $urandom_range(0, 61), $urandom_range(0, 61));
            if (kind < 20) s = {"Wed, ", s, " GMT"};
        end
        else if (kind < 80) begin
            s = $sformatf("%02d:%02d:%02d %s %0d %0d", $urandom_range(0, 23),
                $urandom_range(0, 59), $urandom_range(0, 59), mon, $urandom_range(1, 31),
                $urandom_range(1601, 2400));
        end
        else begin
            s = "";
            repeat ($urandom_range(1, 14)) begin
                byte unsigned b;
                b = 8'($urandom_range(2) == 0 ? $urandom_range(255)
                                              : $urandom_range(8'h20, 8'h7a));
                s = {s, string'(b)};
            end
        end
        return s;
    endfunction

    typedef struct {
        string        text;
        bit           known;
        date_result_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result valid=%0b secs=%0d", $realtime, date_valid,
                         epoch_seconds);
                errors++;
            end
            else begin
                date_result_t w;
                w = pending_dates.pop_front();
                if (date_valid !== w.ok) begin
                    $display("%0t: date_valid expected %0b actual %0b", $realtime, w.ok,
                             date_valid);
                    errors++;
                end
                if (epoch_seconds !== w.secs) begin
                    $display("%0t: epoch_seconds expected %0d actual %0d", $realtime,
                             $signed(w.secs), epoch_seconds);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off counted here
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else if (hold_cnt != 0) begin
            out_stall <= 1'b1;
            hold_cnt--;
        end
        else if (hold_off && !hold_used) begin
            hold_used = 1'b1;
            hold_cnt = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else out_stall <= !long_quiet && $urandom_range(99) < 12;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        date_result_t chk;
        clk = 0; rst_n = 0; in_valid = 0; text_byte = 0; last_byte = 0; out_stall = 0;
        errors = 0; cycles = 0; hold_off = 0; hold_used = 0; hold_cnt = 0;
        long_quiet = 0;
        clear_all();
        dir_rows = '{
            '{"Thu, 01 Jan 1970 00:00:00 GMT", 1, '{1'b1, 39'd0}},
            '{"1 jan 1970 00:00:01", 1, '{1'b1, 39'd1}},
            '{"31 Dec 1969 23:59:59", 1, '{1'b0, 39'd0}},
            '{"1 Jan 1601 00:00:00", 1, '{1'b1, -39'sd11644473600}},
            '{"31 dec 9999 23:59:59", 1, '{1'b1, 39'd253402300799}},
            '{"1 Jan 1600 00:00:00", 1, '{1'b0, 39'd0}},
            '{"32 Jan 2000 00:00:00", 1, '{1'b0, 39'd0}},
            '{"29 Feb 2001 00:00:00", 1, '{1'b0, 39'd0}},
            '{"31 Apr 2000 00:00:00", 1, '{1'b0, 39'd0}},
            '{"1 Jan 2000 24:00:00", 1, '{1'b0, 39'd0}},
            '{"1 Jan 2000 00:60:00", 1, '{1'b0, 39'd0}},
            '{"1 Jan 2000 00:00:60", 1, '{1'b0, 39'd0}},
            '{"1 Jan 2000", 1, '{1'b0, 39'd0}},
            '{" ,;", 1, '{1'b0, 39'd0}},
            '{"x", 1, '{1'b0, 39'd0}},
            '{"29 feb 2000 1:2:3xyz", 0, '0},
            '{"29 Feb 1900 00:00:00", 0, '0},
            '{"1 Jan 69 00:00:00", 0, '0},
            '{"1 Jan 70 00:00:00", 0, '0},
            '{"7 SEPTEMBER 12345 99 10:10:10", 0, '0},
            '{"123:4:5 5 may 2020 8:9:10", 0, '0},
            '{"\xff\x80 9 Nov 2004 \x7e\x09 03:04:05", 0, '0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_text(dir_rows[i].text);
            chk = pending_dates[pending_dates.size() - 1];
            if (dir_rows[i].known && chk !== dir_rows[i].want) begin
                $display("%0t: row %0d expected %0b/%0d predicted %0b/%0d", $realtime, i,
                         dir_rows[i].want.ok, $signed(dir_rows[i].want.secs), chk.ok,
                         $signed(chk.secs));
                errors++;
            end
        end

        // byte range sampled in steps of 17, every bit of both fields toggled
        for (int b = 0; b < 256; b += 17)
            send_byte(b[7:0], b == 255);

        for (int n = 0; n < 20; n++) begin
            string s;
            long_quiet = n >= 4 && n < 10;
            if (n == 12) hold_off = 1'b1;
            s = rand_date();
            send_text(s);
        end
        long_quiet = 0;
        in_valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### filelist.f
rtl/cdp_pkg.sv
rtl/cdp_tokenizer.sv
rtl/cdp_converter.sv
rtl/cookie_date_parser_unit.sv
verif/testbench.sv
